>>> rtl/p1305_pkg.sv
// Shared types and constants for the Poly1305 authenticator.
// Limb widths, key clamp masks, register indexes, sequencer states and
// the control/result bundles of the multiply-accumulate unit. No dependencies.
package p1305_pkg;

    // Radix-2^26 limb arithmetic
    localparam int LIMB_W    = 26;
    localparam int NUM_LIMBS = 5;
    localparam int CNT_W     = 3;
    localparam int BLK_W     = NUM_LIMBS * LIMB_W;

    // Operand widths: h limb is acc + message, r digit is up to 5 * r limb
    localparam int HLIMB_W  = LIMB_W + 1;
    localparam int RDIG_W   = LIMB_W + 3;
    localparam int PROD_W   = HLIMB_W + RDIG_W;
    localparam int MACC_W   = PROD_W + 4;
    localparam int MCARRY_W = MACC_W - LIMB_W;

    // Carry register of the serial carry pass; holds 5 * MAC carry at most
    localparam int CIN_W = MCARRY_W + 3;

    // 2^130 is congruent to 5 mod p
    localparam int FOLD = 5;

    // Word fields
    localparam int KEY_W      = 64;
    localparam int MSG_BYTES  = 16;
    localparam int BYTE_CNT_W = 5;
    localparam int CFG_IDX_W  = 2;

    // r clamp masks
    localparam logic [KEY_W-1:0] R_CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [KEY_W-1:0] R_CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_R_LOW,
        CFG_R_HIGH,
        CFG_S_LOW,
        CFG_S_HIGH
    } p1305_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_CARRY,
        ST_FING,
        ST_FINS,
        ST_PUSH
    } p1305_state_t;

    // Control travelling alongside one limb product
    typedef struct packed {
        logic issue;
        logic first;
        logic limb_end;
    } p1305_mac_ctl_t;

    // Finished limb out of the accumulator
    typedef struct packed {
        logic                valid;
        logic [LIMB_W-1:0]   limb;
        logic [MCARRY_W-1:0] carry;
    } p1305_mac_res_t;

endpackage

>>> rtl/p1305_key.sv
// Key register file: r and s halves, r clamp, limb-digit selection.
// Depends on p1305_pkg.
module p1305_key
    import p1305_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  p1305_cfg_idx_t        wr_index,
    input  logic [KEY_W-1:0]      wr_data,
    input  logic [CNT_W-1:0]      r_idx,
    input  logic                  r_scale,
    input  logic [CNT_W-1:0]      s_idx,
    output logic [RDIG_W-1:0]     r_digit,
    output logic [LIMB_W-1:0]     s_digit
);

    logic [KEY_W-1:0]    r_low_reg;
    logic [KEY_W-1:0]    r_high_reg;
    logic [KEY_W-1:0]    s_low_reg;
    logic [KEY_W-1:0]    s_high_reg;
    logic [BLK_W-1:0]    r_ext;
    logic [BLK_W-1:0]    s_ext;
    logic [LIMB_W-1:0]   r_limb;
    logic [RDIG_W-1:0]   r_wide;

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_R_LOW:  r_low_reg  <= wr_data;
                CFG_R_HIGH: r_high_reg <= wr_data;
                CFG_S_LOW:  s_low_reg  <= wr_data;
                CFG_S_HIGH: s_high_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    // Clamped r and zero-extended s as 130-bit limb vectors
    assign r_ext = BLK_W'({r_high_reg & R_CLAMP_HIGH, r_low_reg & R_CLAMP_LOW});
    assign s_ext = BLK_W'({s_high_reg, s_low_reg});

    // Digit select; wrapped r limbs are scaled by 5
    always_comb
    begin
        r_limb  = '0;
        s_digit = '0;
        for (int q = 0; q < NUM_LIMBS; q++)
        begin
            if (r_idx == CNT_W'(q))
                r_limb = r_ext[q*LIMB_W +: LIMB_W];
            if (s_idx == CNT_W'(q))
                s_digit = s_ext[q*LIMB_W +: LIMB_W];
        end
        r_wide  = RDIG_W'(r_limb);
        r_digit = r_scale ? (r_wide << 2) + r_wide : r_wide;
    end

endmodule

>>> rtl/p1305_mul.sv
// Limb multiply-accumulate: one 27x29 product per cycle, registered,
// then summed into a running column total that emits one limb per column.
// Depends on p1305_pkg.
module p1305_mul
    import p1305_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  p1305_mac_ctl_t        ctl,
    input  logic [HLIMB_W-1:0]    a,
    input  logic [RDIG_W-1:0]     b,
    output p1305_mac_res_t        res
);

    p1305_mac_ctl_t      ctl_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MACC_W-1:0]   acc_reg;
    logic [MACC_W-1:0]   acc_next;
    logic [MACC_W-1:0]   sum;

    // Product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
        acc_reg  <= acc_next;
    end

    // Accumulate stage; a column end hands out the low limb and keeps the carry
    always_comb
    begin
        sum      = (ctl_reg.first ? '0 : acc_reg) + MACC_W'(prod_reg);
        acc_next = acc_reg;
        if (ctl_reg.issue)
            acc_next = ctl_reg.limb_end ? (sum >> LIMB_W) : sum;
        res.valid = ctl_reg.issue && ctl_reg.limb_end;
        res.limb  = sum[LIMB_W-1:0];
        res.carry = sum[MACC_W-1:LIMB_W];
    end

endmodule

>>> rtl/poly1305_mac_top.sv
// Poly1305 authenticator top level: sequencer, limb shift registers,
// serial carry/final-reduction adders and output register.
// Depends on p1305_pkg, p1305_key and p1305_mul.

// Each input word carries one 16-byte block and is worked limb-serially on
// 26-bit digits. A block with a nonzero byte count is accepted, loaded into h,
// multiplied (25 limb products through the one 27x29 multiplier, then a drain
// step) and carried in repeated carry passes until no carry leaves the top limb.
// A last block then adds final reduction and pad addition and moves the tag into
// the output register; a last word with zero count goes straight to final
// reduction. The next word is taken once the block is idle, while a tag may
// still wait in the output register. Keys are to be written through the config
// port only while idle; the block itself does not enforce it. cfg_ready is
// always high. No clearing pass.
module poly1305_mac_top
    import p1305_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [KEY_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [KEY_W-1:0]       message_low,
    input  logic [KEY_W-1:0]       message_high,
    input  logic [BYTE_CNT_W-1:0]  byte_count,
    input  logic                   last_block,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [KEY_W-1:0]       tag_low,
    output logic [KEY_W-1:0]       tag_high
);

    localparam logic [CNT_W-1:0] LAST_LIMB = CNT_W'(NUM_LIMBS - 1);

    p1305_state_t          state_reg;
    p1305_state_t          state_next;
    logic [CNT_W-1:0]      cnt_i_reg;
    logic [CNT_W-1:0]      cnt_i_next;
    logic [CNT_W-1:0]      cnt_k_reg;
    logic [CNT_W-1:0]      cnt_k_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [LIMB_W-1:0]     acc_sr_reg  [NUM_LIMBS];
    logic [LIMB_W-1:0]     acc_sr_next [NUM_LIMBS];
    logic [HLIMB_W-1:0]    h_sr_reg    [NUM_LIMBS];
    logic [HLIMB_W-1:0]    h_sr_next   [NUM_LIMBS];
    logic [BLK_W-1:0]      m_sr_reg;
    logic [BLK_W-1:0]      m_sr_next;
    logic [CIN_W-1:0]      cin_reg;
    logic [CIN_W-1:0]      cin_next;
    logic                  sel_g_reg;
    logic                  sel_g_next;
    logic                  sc_reg;
    logic                  sc_next;
    logic [BLK_W-1:0]      tag_sr_reg;
    logic [BLK_W-1:0]      tag_sr_next;
    logic [2*KEY_W-1:0]    tag_out_reg;
    logic [2*KEY_W-1:0]    tag_out_next;

    logic                  in_fire;
    logic                  push_fire;
    logic                  full_blk;
    logic [2*KEY_W-1:0]    msg;
    logic [BLK_W-1:0]      blk;
    logic [CIN_W:0]        t_pass;
    logic [CIN_W-LIMB_W:0] pass_cout;
    logic [CIN_W-1:0]      cout_ext;
    logic [CIN_W-1:0]      mcarry_ext;
    logic [LIMB_W-1:0]     fin_sel;
    logic [LIMB_W:0]       t_s;

    p1305_mac_ctl_t        mac_ctl;
    p1305_mac_res_t        mac_res;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_scale;
    logic [RDIG_W-1:0]     r_digit;
    logic [LIMB_W-1:0]     s_digit;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign push_fire = (state_reg == ST_PUSH) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign tag_low   = tag_out_reg[KEY_W-1:0];
    assign tag_high  = tag_out_reg[2*KEY_W-1:KEY_W];

    // Key storage
    p1305_key u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (p1305_cfg_idx_t'(cfg_index)),
        .wr_data  (cfg_data),
        .r_idx    (r_idx),
        .r_scale  (r_scale),
        .s_idx    (cnt_i_reg),
        .r_digit  (r_digit),
        .s_digit  (s_digit)
    );

    // Limb multiply-accumulate
    p1305_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (h_sr_reg[0]),
        .b     (r_digit),
        .res   (mac_res)
    );

    // Block padding: short block gets 0x01 after its bytes, full block the 2^128 bit
    always_comb
    begin
        msg      = {message_high, message_low};
        full_blk = (byte_count >= BYTE_CNT_W'(MSG_BYTES));
        blk      = '0;
        for (int b = 0; b < MSG_BYTES; b++)
        begin
            if (full_blk || (BYTE_CNT_W'(b) < byte_count))
                blk[b*8 +: 8] = msg[b*8 +: 8];
            else if (BYTE_CNT_W'(b) == byte_count)
                blk[b*8 +: 8] = 8'h01;
        end
        blk[MSG_BYTES*8] = full_blk;
    end

    // Serial adders: carry pass / +5 compare, and pad addition
    assign t_pass     = (CIN_W+1)'(acc_sr_reg[0]) + (CIN_W+1)'(cin_reg);
    assign pass_cout  = t_pass[CIN_W:LIMB_W];
    assign cout_ext   = CIN_W'(pass_cout);
    assign mcarry_ext = CIN_W'(mac_res.carry);
    assign fin_sel    = sel_g_reg ? h_sr_reg[0][LIMB_W-1:0] : acc_sr_reg[0];
    assign t_s        = (LIMB_W+1)'(fin_sel) + (LIMB_W+1)'(s_digit) + (LIMB_W+1)'(sc_reg);

    // Column k, row i: r digit k-i mod 5, scaled when it wraps
    always_comb
    begin
        r_scale = (cnt_i_reg > cnt_k_reg);
        r_idx   = r_scale ? cnt_k_reg + CNT_W'(NUM_LIMBS) - cnt_i_reg : cnt_k_reg - cnt_i_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_i_next     = cnt_i_reg;
        cnt_k_next     = cnt_k_reg;
        last_next      = last_reg;
        out_valid_next = push_fire || (out_valid_reg && out_stall);
        mac_ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_i_next = '0;
                    cnt_k_next = '0;
                    last_next  = last_block;
                    if (byte_count != '0)
                        state_next = ST_LOAD;
                    else if (last_block)
                        state_next = ST_FING;
                end
            end
            ST_LOAD:
            begin
                cnt_i_next = cnt_i_reg + 1'b1;
                if (cnt_i_reg == LAST_LIMB)
                begin
                    cnt_i_next = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                mac_ctl.issue    = 1'b1;
                mac_ctl.first    = (cnt_i_reg == '0) && (cnt_k_reg == '0);
                mac_ctl.limb_end = (cnt_i_reg == LAST_LIMB);
                cnt_i_next       = cnt_i_reg + 1'b1;
                if (cnt_i_reg == LAST_LIMB)
                begin
                    cnt_i_next = '0;
                    cnt_k_next = cnt_k_reg + 1'b1;
                    if (cnt_k_reg == LAST_LIMB)
                    begin
                        cnt_k_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                cnt_i_next = '0;
                state_next = ST_CARRY;
            end
            ST_CARRY:
            begin
                cnt_i_next = cnt_i_reg + 1'b1;
                if (cnt_i_reg == LAST_LIMB)
                begin
                    cnt_i_next = '0;
                    if (pass_cout == '0)
                        state_next = last_reg ? ST_FING : ST_IDLE;
                end
            end
            ST_FING:
            begin
                cnt_i_next = cnt_i_reg + 1'b1;
                if (cnt_i_reg == LAST_LIMB)
                begin
                    cnt_i_next = '0;
                    state_next = ST_FINS;
                end
            end
            ST_FINS:
            begin
                cnt_i_next = cnt_i_reg + 1'b1;
                if (cnt_i_reg == LAST_LIMB)
                begin
                    cnt_i_next = '0;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath shift registers
    always_comb
    begin
        acc_sr_next  = acc_sr_reg;
        h_sr_next    = h_sr_reg;
        m_sr_next    = m_sr_reg;
        cin_next     = cin_reg;
        sel_g_next   = sel_g_reg;
        sc_next      = sc_reg;
        tag_sr_next  = tag_sr_reg;
        tag_out_next = tag_out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    m_sr_next = blk;
                    cin_next  = CIN_W'(FOLD);
                end
            end
            ST_LOAD:
            begin
                // h = acc + m, one limb a cycle
                for (int q = 0; q < NUM_LIMBS - 1; q++)
                begin
                    h_sr_next[q]   = h_sr_reg[q+1];
                    acc_sr_next[q] = acc_sr_reg[q+1];
                end
                h_sr_next[NUM_LIMBS-1]   = HLIMB_W'(acc_sr_reg[0])
                                         + HLIMB_W'(m_sr_reg[LIMB_W-1:0]);
                acc_sr_next[NUM_LIMBS-1] = '0;
                m_sr_next                = m_sr_reg >> LIMB_W;
            end
            ST_MAC, ST_DRAIN:
            begin
                // h rotates under the multiplier; finished columns enter acc
                if (state_reg == ST_MAC)
                begin
                    for (int q = 0; q < NUM_LIMBS - 1; q++)
                        h_sr_next[q] = h_sr_reg[q+1];
                    h_sr_next[NUM_LIMBS-1] = h_sr_reg[0];
                end
                if (mac_res.valid)
                begin
                    for (int q = 0; q < NUM_LIMBS - 1; q++)
                        acc_sr_next[q] = acc_sr_reg[q+1];
                    acc_sr_next[NUM_LIMBS-1] = mac_res.limb;
                end
                if (state_reg == ST_DRAIN)
                    cin_next = (mcarry_ext << 2) + mcarry_ext;
            end
            ST_CARRY:
            begin
                // Carry pass; carry out of the top limb folds back times 5
                for (int q = 0; q < NUM_LIMBS - 1; q++)
                    acc_sr_next[q] = acc_sr_reg[q+1];
                acc_sr_next[NUM_LIMBS-1] = t_pass[LIMB_W-1:0];
                cin_next                 = cout_ext;
                if (cnt_i_reg == LAST_LIMB)
                    cin_next = (pass_cout == '0) ? CIN_W'(FOLD) : (cout_ext << 2) + cout_ext;
            end
            ST_FING:
            begin
                // g = h + 5; a carry out of the top limb means h >= p
                for (int q = 0; q < NUM_LIMBS - 1; q++)
                begin
                    acc_sr_next[q] = acc_sr_reg[q+1];
                    h_sr_next[q]   = h_sr_reg[q+1];
                end
                acc_sr_next[NUM_LIMBS-1] = acc_sr_reg[0];
                h_sr_next[NUM_LIMBS-1]   = HLIMB_W'(t_pass[LIMB_W-1:0]);
                cin_next                 = cout_ext;
                sc_next                  = 1'b0;
                if (cnt_i_reg == LAST_LIMB)
                    sel_g_next = (pass_cout != '0);
            end
            ST_FINS:
            begin
                // tag = reduced h + s; accumulator clears as it shifts out
                for (int q = 0; q < NUM_LIMBS - 1; q++)
                begin
                    acc_sr_next[q] = acc_sr_reg[q+1];
                    h_sr_next[q]   = h_sr_reg[q+1];
                end
                acc_sr_next[NUM_LIMBS-1] = '0;
                h_sr_next[NUM_LIMBS-1]   = '0;
                tag_sr_next = {t_s[LIMB_W-1:0], tag_sr_reg[BLK_W-1:LIMB_W]};
                sc_next     = t_s[LIMB_W];
            end
            ST_PUSH:
            begin
                if (push_fire)
                    tag_out_next = tag_sr_reg[2*KEY_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Control registers and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_i_reg     <= '0;
            cnt_k_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int q = 0; q < NUM_LIMBS; q++)
                acc_sr_reg[q] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_i_reg     <= cnt_i_next;
            cnt_k_reg     <= cnt_k_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            acc_sr_reg    <= acc_sr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        h_sr_reg    <= h_sr_next;
        m_sr_reg    <= m_sr_next;
        cin_reg     <= cin_next;
        sel_g_reg   <= sel_g_next;
        sc_reg      <= sc_next;
        tag_sr_reg  <= tag_sr_next;
        tag_out_reg <= tag_out_next;
    end

    // Finished limbs only come out during the multiply phase
    a_mac_limb_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.valid |-> (state_reg == ST_MAC || state_reg == ST_DRAIN))
        else $error("limb left the multiplier outside the multiply phase");

    // A tag appears only after the hand-off state
    a_tag_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUSH))
        else $error("tag word raised without hand-off");

    // A tag belongs to a last block
    a_tag_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last_reg))
        else $error("tag word raised for a block that was not last");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the Poly1305 authenticator top level.
// Holds its own modular-arithmetic model of the tag and compares every tag word.
// Depends on p1305_pkg and poly1305_mac_top.
module tb_top
    import p1305_pkg::*;
();

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int ITEMS_TOTAL   = 1700;
    localparam int QUIET_TAIL    = 250;
    localparam int SETTLE_CYCLES = 80;
    localparam int STUCK_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;

    // p = 2^130 - 5, held wide enough for a full product
    localparam logic [259:0] POLY_P = (260'd1 << 130) - 260'd5;

    typedef struct packed {
        logic [KEY_W-1:0] low;
        logic [KEY_W-1:0] high;
    } tag_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [KEY_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [KEY_W-1:0]      message_low;
    logic [KEY_W-1:0]      message_high;
    logic [BYTE_CNT_W-1:0] byte_count;
    logic                  last_block;
    logic                  out_valid;
    logic                  out_stall;
    logic [KEY_W-1:0]      tag_low;
    logic [KEY_W-1:0]      tag_high;

    // Model state: key copy and accumulator kept fully reduced mod p
    logic [KEY_W-1:0] key_r_low;
    logic [KEY_W-1:0] key_r_high;
    logic [KEY_W-1:0] key_s_low;
    logic [KEY_W-1:0] key_s_high;
    logic [129:0]     poly_acc;

    tag_word_t   pending_tags[$];
    int unsigned mismatches;
    int unsigned words_sent;
    bit          bursts_on;
    bit          word_gaps;

    poly1305_mac_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_low  (message_low),
        .message_high (message_high),
        .byte_count   (byte_count),
        .last_block   (last_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tag_low      (tag_low),
        .tag_high     (tag_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Tag model
    // ---------------------------------------------------------------

    // Pad a nonzero-count block per its byte count, add to the accumulator, multiply by clamped r
    function automatic void absorb_word(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                                        input logic [BYTE_CNT_W-1:0] cnt);
        logic [127:0] data;
        logic [127:0] keep;
        logic [259:0] blk;
        logic [259:0] r_clamped;
        logic [259:0] sum;
        data = {hi, lo};
        if (cnt == 0)
            return;
        if (cnt >= MSG_BYTES)
            blk = 260'(data) | (260'd1 << 128);
        else
        begin
            keep = (128'd1 << (8 * cnt)) - 128'd1;
            blk  = 260'((data & keep) | (128'd1 << (8 * cnt)));
        end
        r_clamped = 260'({key_r_high & R_CLAMP_HIGH, key_r_low & R_CLAMP_LOW});
        sum       = (260'(poly_acc) + blk) % POLY_P;
        poly_acc  = 130'((sum * r_clamped) % POLY_P);
    endfunction

    // Final tag: reduced accumulator plus s, mod 2^128; clears the accumulator
    function automatic tag_word_t compute_tag();
        logic [127:0] t;
        tag_word_t    w;
        t        = poly_acc[127:0] + {key_s_high, key_s_low};
        w.low    = t[63:0];
        w.high   = t[127:64];
        poly_acc = '0;
        return w;
    endfunction

    // Random 64-bit value, with the extremes now and then
    function automatic logic [KEY_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] exp_val,
                                   input logic [KEY_W-1:0] act_val);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("ERROR %s: expected %h, got %h", what, exp_val, act_val);
    endtask

    // ---------------------------------------------------------------
    // Drivers (each task is entered and left at a falling edge)
    // ---------------------------------------------------------------

    // Write one key register; cfg_valid is left high for back-to-back writes
    task automatic write_key_reg(input p1305_cfg_idx_t idx, input logic [KEY_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_R_LOW:  key_r_low  = val;
            CFG_R_HIGH: key_r_high = val;
            CFG_S_LOW:  key_s_low  = val;
            CFG_S_HIGH: key_s_high = val;
            default:    ;
        endcase
        @(negedge clk);
    endtask

    // Write the registers selected by sel (bit i = register index i)
    task automatic load_key(input logic [3:0] sel, input logic [KEY_W-1:0] r_lo,
                            input logic [KEY_W-1:0] r_hi, input logic [KEY_W-1:0] s_lo,
                            input logic [KEY_W-1:0] s_hi);
        logic [KEY_W-1:0] vals [4];
        vals[0] = r_lo;
        vals[1] = r_hi;
        vals[2] = s_lo;
        vals[3] = s_hi;
        for (int i = 0; i < 4; i++)
            if (sel[i])
                write_key_reg(p1305_cfg_idx_t'(i), vals[i]);
        cfg_valid <= 1'b0;
    endtask

    // Send one message word, then predict; in_valid stays high afterwards
    task automatic push_block(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                              input logic [BYTE_CNT_W-1:0] cnt, input logic last);
        int unsigned gap;
        if (bursts_on && word_gaps && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        message_low  <= lo;
        message_high <= hi;
        byte_count   <= cnt;
        last_block   <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        words_sent++;
        absorb_word(lo, hi, cnt);
        if (last)
            pending_tags.push_back(compute_tag());
    endtask

    // Stop sending, let every tag come out, then give the engine time to go idle
    task automatic wait_engine_idle();
        in_valid <= 1'b0;
        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset key is all zero, so an empty message gives a zero tag
    task automatic test_empty_message();
        push_block(rand_word(), rand_word(), 5'd0, 1'b1);
        wait_engine_idle();
    endtask

    // Standard published vector: 34-byte message, garbage above the short count
    task automatic test_known_vector();
        load_key(4'hf, 64'h336d555778bed685, 64'ha806d542fe52447f,
                 64'hfdb20dfb8a800301, 64'h1bf54941aff6bf4a);
        push_block(64'h72676f7470797243, 64'h6f46206369687061, 5'd16, 1'b0);
        push_block(64'h65736552206d7572, 64'h6f72472068637261, 5'd16, 1'b0);
        push_block(64'hdeadbeefcafe7075, 64'h0123456789abcdef, 5'd2, 1'b1);
        wait_engine_idle();
    endtask

    // All-ones key and data: largest limb products and a carry out of the s add
    task automatic test_saturated_operands();
        load_key(4'hf, '1, '1, '1, '1);
        push_block('1, '1, 5'd16, 1'b0);
        push_block('1, '1, 5'd16, 1'b0);
        push_block('1, '1, 5'd16, 1'b1);
        wait_engine_idle();
    endtask

    // r = 1: two all-ones blocks sum to 2^130 - 2, which must be reduced below p
    task automatic test_modulus_wrap();
        load_key(4'b0011, 64'd1, 64'd0, '0, '0);
        push_block('1, '1, 5'd16, 1'b0);
        push_block('1, '1, 5'd16, 1'b1);
        wait_engine_idle();
    endtask

    // Zero, short and oversize counts mid-message, then a short last block
    task automatic test_byte_counts();
        load_key(4'hf, rand_word(), rand_word(), rand_word(), rand_word());
        push_block(rand_word(), rand_word(), 5'd0, 1'b0);
        push_block('1, '1, 5'd1, 1'b0);
        push_block(rand_word(), rand_word(), 5'd7, 1'b0);
        push_block('1, '1, 5'd8, 1'b0);
        push_block(rand_word(), rand_word(), 5'd9, 1'b0);
        push_block('1, '1, 5'd15, 1'b0);
        push_block(rand_word(), rand_word(), 5'd17, 1'b0);
        push_block(rand_word(), rand_word(), 5'd31, 1'b0);
        push_block('1, '1, 5'd15, 1'b1);
        wait_engine_idle();
    endtask

    // New key between two words of one message
    task automatic test_rekey_mid_message();
        load_key(4'hf, rand_word(), rand_word(), rand_word(), rand_word());
        push_block(rand_word(), rand_word(), 5'd16, 1'b0);
        wait_engine_idle();
        load_key(4'hf, rand_word(), rand_word(), rand_word(), rand_word());
        push_block(rand_word(), rand_word(), 5'd16, 1'b1);
        wait_engine_idle();
    endtask

    // Random messages: mostly full blocks plus a last block, some noise words
    task automatic test_random_messages();
        int unsigned           nblk;
        logic [BYTE_CNT_W-1:0] cnt;
        while (words_sent < ITEMS_TOTAL)
        begin
            if (words_sent > ITEMS_TOTAL - QUIET_TAIL)
                bursts_on = 1'b0;
            word_gaps = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0)
            begin
                wait_engine_idle();
                load_key(4'($urandom_range(1, 15)), rand_word(), rand_word(), rand_word(),
                         rand_word());
            end
            nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 4);
            for (int b = 0; b < nblk; b++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    wait_engine_idle();
                    load_key(4'($urandom_range(1, 15)), rand_word(), rand_word(), rand_word(),
                             rand_word());
                end
                if ($urandom_range(0, 11) == 0)
                    cnt = BYTE_CNT_W'($urandom_range(0, 15));
                else if ($urandom_range(0, 7) == 0)
                    cnt = BYTE_CNT_W'($urandom_range(17, 31));
                else
                    cnt = BYTE_CNT_W'(MSG_BYTES);
                push_block(rand_word(), rand_word(), cnt, 1'b0);
            end
            case ($urandom_range(0, 9))
                0:             cnt = '0;
                1, 2, 3, 4, 5: cnt = BYTE_CNT_W'($urandom_range(1, 15));
                6, 7:          cnt = BYTE_CNT_W'(MSG_BYTES);
                default:       cnt = BYTE_CNT_W'($urandom_range(17, 31));
            endcase
            push_block(rand_word(), rand_word(), cnt, 1'b1);
        end
        wait_engine_idle();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        message_low  = '0;
        message_high = '0;
        byte_count   = '0;
        last_block   = 1'b0;
        key_r_low    = '0;
        key_r_high   = '0;
        key_s_low    = '0;
        key_s_high   = '0;
        poly_acc     = '0;
        mismatches   = 0;
        words_sent   = 0;
        bursts_on    = 1'b1;
        word_gaps    = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_message();
        test_known_vector();
        test_saturated_operands();
        test_modulus_wrap();
        test_byte_counts();
        test_rekey_mid_message();
        test_random_messages();

        if (pending_tags.size() != 0)
        begin
            mismatches += pending_tags.size();
            $display("ERROR %0d expected tags never arrived", pending_tags.size());
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver stalls: random bursts, with quiet stretches in between
    initial
    begin : out_stall_gen
        int unsigned n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (bursts_on && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                n = $urandom_range(30, 120);
                repeat (n) @(negedge clk);
            end
        end
    end

    // Tag checker: each accepted tag against the oldest prediction
    initial
    begin : tag_checker
        tag_word_t exp_tag;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_tags.size() == 0)
                    report_mismatch("unexpected tag, low word", '0, tag_low);
                else
                begin
                    exp_tag = pending_tags.pop_front();
                    if (tag_low !== exp_tag.low)
                        report_mismatch("tag_low", exp_tag.low, tag_low);
                    if (tag_high !== exp_tag.high)
                        report_mismatch("tag_high", exp_tag.high, tag_high);
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TIMEOUT: no handshake for %0d cycles", STUCK_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> poly1305_mac_top.f
rtl/p1305_pkg.sv
rtl/p1305_key.sv
rtl/p1305_mul.sv
rtl/poly1305_mac_top.sv
dv/tb_top.sv
